>>> hw/rtl/buddy_free_coalescer_unit_macros.svh
// ----------------------------------------------------------------------------
// Buddy free coalescer assertion macros
// Shared concurrent assertion wrappers for the coalescer checker.
// ----------------------------------------------------------------------------
`ifndef BUDDY_FREE_COALESCER_UNIT_MACROS_SVH
`define BUDDY_FREE_COALESCER_UNIT_MACROS_SVH

// Check on every rising edge, reset included.
`define BFC_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check on every rising edge, ignored while reset is high.
`define BFC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> hw/rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// Buddy free coalescer package
// Field widths, operation codes and the item types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

   localparam int OP_W        = 1;
   localparam int ORDER_W     = 4;
   localparam int ADDRESS_W   = 10;
   localparam int MERGE_W     = 4;
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 1;

   localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [ORDER_W-1:0]   order;
      logic [ADDRESS_W-1:0] address;
   } bfc_request_type;

   typedef struct packed {
      logic [ORDER_W-1:0]   final_order;
      logic [ADDRESS_W-1:0] final_address;
      logic [MERGE_W-1:0]   merge_count;
      logic                 misaligned;
   } bfc_result_type;

endpackage

`default_nettype wire

>>> hw/rtl/bfc_ram.sv
// ----------------------------------------------------------------------------
// Buddy free coalescer generic RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2047
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy free coalescer sequencer
// Clears the free map, then walks each item's buddy chain one order a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ctrl #(
   parameter int NUM_ORDERS = 11
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bfc_pkg::bfc_request_type req,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output bfc_pkg::bfc_result_type      res,
   output logic                         res_valid,
   input  wire logic                    res_ready,
   output logic                         mem_we,
   output logic [NUM_ORDERS-1:0]        mem_waddr,
   output logic [0:0]                   mem_wdata,
   output logic                         mem_re,
   output logic [NUM_ORDERS-1:0]        mem_raddr,
   input  wire logic [0:0]              mem_rdata
);

   import bfc_pkg::*;

   localparam int KW        = $clog2(NUM_ORDERS);
   localparam int AW        = NUM_ORDERS - 1;
   localparam int IW        = NUM_ORDERS;
   localparam int MAP_DEPTH = (1 << NUM_ORDERS) - 1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ORDER_W-1:0]   ord_ff, ord_in;
   logic [ADDRESS_W-1:0] adr_ff, adr_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [AW-1:0]        a_ff, a_in;
   logic [KW-1:0]        mrg_ff, mrg_in;
   logic [IW-1:0]        bud_ff, bud_in;
   logic [IW-1:0]        clr_ff, clr_in;
   bfc_result_type       res_ff, res_in;

   // map position of block (k, a): orders stacked from the finest up
   function automatic logic [IW-1:0] map_idx(input logic [KW-1:0] k, input logic [AW-1:0] a);
      logic [31:0] full;
      logic [31:0] pos;
      full = 32'd1 << NUM_ORDERS;
      pos  = full - (full >> k) + (32'(a) >> k);
      return pos[IW-1:0];
   endfunction

   function automatic logic [AW-1:0] size_bit(input logic [KW-1:0] k);
      logic [31:0] b;
      b = 32'd1 << k;
      return b[AW-1:0];
   endfunction

   function automatic logic below_top(input logic [KW-1:0] k);
      return (32'(k) + 32'd1) < 32'(NUM_ORDERS);
   endfunction

   logic [31:0]   ev_ord32;
   logic [31:0]   ev_adr32;
   logic          ev_bad;
   logic [KW-1:0] ev_k;
   logic [AW-1:0] ev_a;
   logic [IW-1:0] ev_bud;
   logic [KW-1:0] ck_k;
   logic [AW-1:0] ck_a;
   logic [IW-1:0] ck_bud;
   logic [IW-1:0] fin_idx;

   assign ev_ord32 = 32'(ord_ff);
   assign ev_adr32 = 32'(adr_ff);
   assign ev_bad   = (ev_ord32 >= 32'(NUM_ORDERS)) || ((ev_adr32 >> AW) != 32'd0) ||
                     ((ev_adr32 & ((32'd1 << ev_ord32) - 32'd1)) != 32'd0);
   assign ev_k     = ev_ord32[KW-1:0];
   assign ev_a     = ev_adr32[AW-1:0];
   assign ev_bud   = map_idx(ev_k, ev_a ^ size_bit(ev_k));
   assign ck_k     = k_ff + KW'(1);
   assign ck_a     = a_ff & ~size_bit(k_ff);
   assign ck_bud   = map_idx(ck_k, ck_a ^ size_bit(ck_k));
   assign fin_idx  = map_idx(k_ff, a_ff);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ord_in    = ord_ff;
      adr_in    = adr_ff;
      k_in      = k_ff;
      a_in      = a_ff;
      mrg_in    = mrg_ff;
      bud_in    = bud_ff;
      clr_in    = clr_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == IW'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req.operation;
               ord_in   = req.order;
               adr_in   = req.address;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (ev_bad) begin
               res_in.final_order   = ord_ff;
               res_in.final_address = adr_ff;
               res_in.merge_count   = '0;
               res_in.misaligned    = 1'b1;
               state_in             = ST_DONE;
            end else begin
               k_in   = ev_k;
               a_in   = ev_a;
               mrg_in = '0;
               if (op_ff == OP_RELEASE && below_top(ev_k)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ev_bud;
                  bud_in    = ev_bud;
                  state_in  = ST_CHECK;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_CHECK: begin
            if (mem_rdata[0]) begin
               // buddy free: take it off the map and climb one order
               mem_we    = 1'b1;
               mem_waddr = bud_ff;
               k_in      = ck_k;
               a_in      = ck_a;
               mrg_in    = mrg_ff + KW'(1);
               if (below_top(ck_k)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ck_bud;
                  bud_in    = ck_bud;
               end else begin
                  state_in = ST_FINAL;
               end
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            mem_we               = 1'b1;
            mem_waddr            = fin_idx;
            mem_wdata            = 1'b1;
            res_in.final_order   = ORDER_W'(32'(k_ff));
            res_in.final_address = ADDRESS_W'(32'(a_ff));
            res_in.merge_count   = MERGE_W'(32'(mrg_ff));
            res_in.misaligned    = 1'b0;
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      ord_ff <= ord_in;
      adr_ff <= adr_in;
      k_ff   <= k_in;
      a_ff   <= a_in;
      mrg_ff <= mrg_in;
      bud_ff <= bud_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire

>>> hw/rtl/buddy_free_coalescer_unit.sv
// ----------------------------------------------------------------------------
// Buddy free coalescer unit
// Buddy-system free map with release coalescing, kept in one bit RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request items arrive on req_*: tuser carries the operation (load or
//   release), tdata the block order and start address. Each item yields
//   exactly one result item on rsp_*: final order, final address and merge
//   count in tdata, the misaligned flag in tuser.
//   Timing: the sequencer accepts the item, checks it, reads the buddy's map
//   bit per order of a release and clears it while the buddy is free, marks
//   the final block and hands the result over. A misaligned item skips the
//   buddy walk and the final mark; a load skips the buddy walk. The buddy
//   chain through the map RAM sets the rate; a new item is accepted only
//   after the last result is handed over to the output register.
//   Reset: the map RAM is cleared by a pass over all 2^NUM_ORDERS - 1
//   entries (2047 by default); req_tready stays low until it completes.
//   Stall: a result waits in the output register while rsp_tready is low;
//   the next item is still accepted and worked on, and holds in its last
//   stage only once both the register and that stage are full.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_free_coalescer_unit #(
   parameter int NUM_ORDERS = 11
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: order[3:0], address[13:4], zero pad[15:14]
   input  wire logic [bfc_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation[0]
   input  wire logic [bfc_pkg::REQ_USER_W-1:0] req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: final_order[3:0], final_address[13:4], merge_count[17:14], zero pad[23:18]
   output logic      [bfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: misaligned[0]
   output logic      [bfc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import bfc_pkg::*;

   localparam int MAP_DEPTH = (1 << NUM_ORDERS) - 1;

   bfc_request_type         req;
   bfc_result_type          res;
   logic                    res_valid;
   logic                    res_ready;
   logic                    mem_we;
   logic [NUM_ORDERS-1:0]   mem_waddr;
   logic [0:0]              mem_wdata;
   logic                    mem_re;
   logic [NUM_ORDERS-1:0]   mem_raddr;
   logic [0:0]              mem_rdata;

   logic                    out_valid_ff, out_valid_in;
   bfc_result_type          out_data_ff, out_data_in;

   // unpack the request item
   assign req.operation = req_tuser[OP_W-1:0];
   assign req.order     = req_tdata[ORDER_W-1:0];
   assign req.address   = req_tdata[ORDER_W +: ADDRESS_W];

   bfc_ctrl #(
      .NUM_ORDERS (NUM_ORDERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .res       (res),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // one free bit per block position of every order
   bfc_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register: take a new result when empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_data_in  = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   // pack the result item, pad to whole bytes
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - ORDER_W - ADDRESS_W - MERGE_W)'(0),
                        out_data_ff.merge_count,
                        out_data_ff.final_address,
                        out_data_ff.final_order};
   assign rsp_tuser  = out_data_ff.misaligned;

endmodule

`default_nettype wire

>>> hw/rtl/bfc_checker.sv
// ----------------------------------------------------------------------------
// Buddy free coalescer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_free_coalescer_unit_macros.svh"

module bfc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [bfc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import bfc_pkg::*;

   logic [ORDER_W-1:0]               rsp_order;
   logic [ADDRESS_W-1:0]             rsp_address;
   logic [MERGE_W-1:0]               rsp_merges;
   logic [ADDRESS_W-1:0]             rsp_mask;
   logic [ADDRESS_W-1:0]             rsp_offset;
   logic [RSP_USER_W+RSP_DATA_W-1:0] rsp_item;
   logic                             held;
   logic                             bad_rsp;
   logic                             good_rsp;

   assign rsp_order   = rsp_tdata[ORDER_W-1:0];
   assign rsp_address = rsp_tdata[ORDER_W +: ADDRESS_W];
   assign rsp_merges  = rsp_tdata[ORDER_W + ADDRESS_W +: MERGE_W];
   assign rsp_mask    = ADDRESS_W'(ADDRESS_W'(1) << rsp_order) - ADDRESS_W'(1);
   assign rsp_offset  = rsp_address & rsp_mask;
   assign rsp_item    = {rsp_tuser, rsp_tdata};
   assign held        = rsp_tvalid && !rsp_tready;
   assign bad_rsp     = rsp_tvalid && rsp_tuser[0];
   assign good_rsp    = rsp_tvalid && !rsp_tuser[0];

   // the map clear blocks requests and no result is left over after reset
   `BFC_ASSERT_CLK(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready, "busy after reset")

   // a stalled result holds
   `BFC_ASSERT_RST(a_rsp_hold, clock, reset, held |=> rsp_tvalid && $stable(rsp_item), "result moved")

   // an ignored item never merges
   `BFC_ASSERT_RST(a_bad_no_merge, clock, reset, bad_rsp |-> rsp_merges == '0, "ignored item merged")

   // a recorded block is aligned to its own size
   `BFC_ASSERT_RST(a_final_aligned, clock, reset, good_rsp |-> rsp_offset == '0, "block misaligned")

endmodule

bind buddy_free_coalescer_unit bfc_checker u_bfc_checker (.*);

`default_nettype wire
